// ===== rtl/scv_pkg.sv =====
`default_nettype none

package scv_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XSTART,
        ST_XMUL,
        ST_XACC,
        ST_XWR,
        ST_XNEXT,
        ST_CHECK,
        ST_YADDR,
        ST_YMUL,
        ST_YACC,
        ST_EMIT
    } t_seq_state;

    // register indexes on the configuration port
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_KERNEL_TAPS   = 3'd2;
    localparam logic [2:0] REG_X_COEFFS_LOW  = 3'd3;
    localparam logic [2:0] REG_X_COEFFS_HIGH = 3'd4;
    localparam logic [2:0] REG_Y_COEFFS_LOW  = 3'd5;
    localparam logic [2:0] REG_Y_COEFFS_HIGH = 3'd6;

    localparam int ACC_W  = 53;
    localparam int PROD_W = 48;

    // operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Q2.14 coefficient i out of two packed 64-bit words; taps 8 and up are zero
    function automatic logic signed [15:0] tap(input logic [63:0] lo, input logic [63:0] hi,
                                               input logic [4:0] idx);
        logic [63:0] sel;
        begin
            sel = idx[2] ? hi : lo;
            if (idx >= 5'd8) begin
                tap = 16'sd0;
            end else begin
                tap = $signed(sel[{idx[1:0], 4'b0000} +: 16]);
            end
        end
    endfunction

    // round half up out of Q.14, then saturate to signed 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] v;
        logic signed [ACC_W-14:0] q;
        begin
            v = {a[ACC_W-1], a} + 54'sd8192;
            q = v[ACC_W:14];
            if (q > 40'sd2147483647) begin
                round_sat = 32'sh7fffffff;
            end else if (q < -40'sd2147483648) begin
                round_sat = 32'sh80000000;
            end else begin
                round_sat = q[31:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/scv_ram.sv =====
`default_nettype none

module scv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/separable_image_convolution_core.sv =====
`default_nettype none

// Separable 2-D convolution, zero padded, on a raster pixel stream. Each pixel item runs an
// x-kernel pass whose rounded result goes to a line store of MAX_TAPS rows, then, once the
// needed rows have arrived, a y-kernel pass over that store gives one output pixel in raster
// order. Drain items (or pixels arriving after the frame's last input) flush the remaining
// outputs. Each result is built one product at a time in a single accumulator, the last
// pixel of a row runs up to h extra x results (h = (T-1)/2), and a finished result waits
// while the output register is still held by the receiver. The line store is a single RAM
// with one write and one registered read port. The next item is taken while a result still
// waits on the output register.
module separable_image_convolution_core #(
    parameter int MAX_TAPS   = 8,
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic      [63:0]        prdata,
    output logic                    pready,
    // input channel
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_operation,
    input  wire logic signed [23:0] i_pixel_value,
    // output channel
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_filtered_value,
    output logic [11:0]             o_out_row,
    output logic [10:0]             o_out_column,
    output logic                    o_last_of_frame
);

    localparam int TW    = $clog2(MAX_TAPS + 1);
    localparam int SW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_TAPS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int ACC_W  = scv_pkg::ACC_W;
    localparam int PROD_W = scv_pkg::PROD_W;

    // ---------------- configuration registers ----------------
    logic [11:0] r_image_width;
    logic [12:0] r_image_height;
    logic [3:0]  r_kernel_taps;
    logic [63:0] r_x_lo, r_x_hi, r_y_lo, r_y_hi;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 12'd1024;
            r_image_height <= 13'd1024;
            r_kernel_taps  <= 4'd1;
            r_x_lo         <= 64'd16384;
            r_x_hi         <= 64'd0;
            r_y_lo         <= 64'd16384;
            r_y_hi         <= 64'd0;
        end else if (w_cfg_wr) begin
            case (paddr[5:3])
                scv_pkg::REG_IMAGE_WIDTH:   r_image_width  <= pwdata[11:0];
                scv_pkg::REG_IMAGE_HEIGHT:  r_image_height <= pwdata[12:0];
                scv_pkg::REG_KERNEL_TAPS:   r_kernel_taps  <= pwdata[3:0];
                scv_pkg::REG_X_COEFFS_LOW:  r_x_lo         <= pwdata;
                scv_pkg::REG_X_COEFFS_HIGH: r_x_hi         <= pwdata;
                scv_pkg::REG_Y_COEFFS_LOW:  r_y_lo         <= pwdata;
                scv_pkg::REG_Y_COEFFS_HIGH: r_y_hi         <= pwdata;
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[5:3])
            scv_pkg::REG_IMAGE_WIDTH:   prdata = {52'd0, r_image_width};
            scv_pkg::REG_IMAGE_HEIGHT:  prdata = {51'd0, r_image_height};
            scv_pkg::REG_KERNEL_TAPS:   prdata = {60'd0, r_kernel_taps};
            scv_pkg::REG_X_COEFFS_LOW:  prdata = r_x_lo;
            scv_pkg::REG_X_COEFFS_HIGH: prdata = r_x_hi;
            scv_pkg::REG_Y_COEFFS_LOW:  prdata = r_y_lo;
            scv_pkg::REG_Y_COEFFS_HIGH: prdata = r_y_hi;
            default:                    prdata = 64'd0;
        endcase
    end

    // clamped frame geometry and kernel size
    logic [CW-1:0] w_w;
    logic [RW-1:0] w_h;
    logic [TW-1:0] w_t, w_hh;

    always_comb begin
        if (r_image_width == 12'd0) begin
            w_w = CW'(1);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            w_w = CW'(MAX_WIDTH);
        end else begin
            w_w = CW'(r_image_width);
        end
        if (r_image_height == 13'd0) begin
            w_h = RW'(1);
        end else if (32'(r_image_height) > 32'(MAX_HEIGHT)) begin
            w_h = RW'(MAX_HEIGHT);
        end else begin
            w_h = RW'(r_image_height);
        end
        if (r_kernel_taps == 4'd0) begin
            w_t = TW'(1);
        end else if (32'(r_kernel_taps) > 32'(MAX_TAPS)) begin
            w_t = TW'(MAX_TAPS);
        end else begin
            w_t = TW'(r_kernel_taps);
        end
        w_hh = (w_t - TW'(1)) >> 1;
    end

    // ---------------- state ----------------
    scv_pkg::t_seq_state r_state, n_state;

    logic signed [23:0]       r_win [MAX_TAPS];
    logic                     r_op, n_op;
    logic signed [23:0]       r_px;
    logic [RW-1:0]            r_in_row, n_in_row, r_out_row, n_out_row;
    logic [CW-1:0]            r_in_col, n_in_col, r_out_col, n_out_col;
    logic [SW-1:0]            r_in_slot, n_in_slot, r_out_slot, n_out_slot;
    logic [SW-1:0]            r_y_slot, n_y_slot;
    logic                     r_done, n_done;
    logic [TW-1:0]            r_s, n_s, r_j, n_j;
    logic signed [RW+1:0]     r_sr, n_sr;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic                     r_o_valid, n_o_valid;
    logic signed [31:0]       r_o_val, n_o_val;
    logic [11:0]              r_o_row, n_o_row;
    logic [10:0]              r_o_col, n_o_col;
    logic                     r_o_last, n_o_last;
    logic                     w_accept, w_win_load;

    // line store
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_wdata, w_rdata;

    scv_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_line_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_ready          = (r_state == scv_pkg::ST_IDLE);
    assign w_accept         = i_valid & o_ready;
    assign w_win_load       = w_accept & (i_operation == scv_pkg::OP_PIXEL) & ~r_done;
    assign o_valid          = r_o_valid;
    assign o_filtered_value = r_o_val;
    assign o_out_row        = r_o_row;
    assign o_out_column     = r_o_col;
    assign o_last_of_frame  = r_o_last;

    // row window: cleared at row start, newest pixel at index 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_win[k] <= '0;
            end
        end else if (w_win_load) begin
            for (int k = MAX_TAPS - 1; k > 0; k--) begin
                r_win[k] <= (r_in_col == '0) ? 24'sd0 : r_win[k-1];
            end
            r_win[0] <= i_pixel_value;
        end
    end

    // datapath helpers
    logic signed [15:0]    w_tx, w_ty;
    logic signed [39:0]    w_xprod;
    logic signed [47:0]    w_yprod;
    logic [TW-1:0]         w_widx;
    logic [CW:0]           w_col_s, w_store_col;
    logic [TW-1:0]         w_s_last;
    logic                  w_in_last_col, w_in_last_row;
    logic                  w_out_last_col, w_out_last_row;
    logic [RW:0]           w_rn;
    logic [CW:0]           w_cn;
    logic                  w_out_ready;
    logic                  w_sr_ok;
    logic [31:0]           w_slot_sum;

    always_comb begin
        w_tx     = scv_pkg::tap(r_x_lo, r_x_hi, 5'(r_j));
        w_ty     = scv_pkg::tap(r_y_lo, r_y_hi, 5'(r_j));
        w_widx   = r_j - r_s;
        w_xprod  = w_tx * r_win[SW'(w_widx)];
        w_yprod  = w_ty * $signed(w_rdata);
        w_col_s  = (CW+1)'(r_in_col) + (CW+1)'(r_s);
        w_store_col = w_col_s - (CW+1)'(w_hh);
        w_in_last_col  = r_in_col >= (w_w - CW'(1));
        w_in_last_row  = r_in_row >= (w_h - RW'(1));
        w_out_last_col = r_out_col >= (w_w - CW'(1));
        w_out_last_row = r_out_row >= (w_h - RW'(1));
        w_s_last = w_in_last_col ? w_hh : '0;
        // readiness of the next output
        w_rn = (RW+1)'(r_out_row) + (RW+1)'(w_hh);
        if (w_rn > (RW+1)'(w_h - RW'(1))) begin
            w_rn = (RW+1)'(w_h - RW'(1));
        end
        w_cn = (CW+1)'(r_out_col) + (CW+1)'(w_hh);
        if (w_cn > (CW+1)'(w_w - CW'(1))) begin
            w_cn = (CW+1)'(w_w - CW'(1));
        end
        w_out_ready = r_done || ((RW+1)'(r_in_row) > w_rn) ||
                      (((RW+1)'(r_in_row) == w_rn) && ((CW+1)'(r_in_col) > w_cn));
        w_sr_ok    = (r_sr >= 0) && (r_sr < $signed((RW+2)'(w_h)));
        w_slot_sum = 32'(r_out_slot) + 32'(w_hh);
        if (w_slot_sum >= 32'(MAX_TAPS)) begin
            w_slot_sum = w_slot_sum - 32'(MAX_TAPS);
        end
    end

    // line store ports
    assign w_we    = (r_state == scv_pkg::ST_XWR);
    assign w_waddr = AW'(32'(r_in_slot) * MAX_WIDTH + 32'(w_store_col[CW-1:0]));
    assign w_wdata = scv_pkg::round_sat(r_acc);
    assign w_re    = (r_state == scv_pkg::ST_YADDR) && (r_j < w_t) && w_sr_ok;
    assign w_raddr = AW'(32'(r_y_slot) * MAX_WIDTH + 32'(r_out_col));

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_in_slot  = r_in_slot;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_slot = r_out_slot;
        n_y_slot   = r_y_slot;
        n_done     = r_done;
        n_s        = r_s;
        n_j        = r_j;
        n_sr       = r_sr;
        n_acc      = r_acc;
        n_prod     = r_prod;
        n_o_valid  = r_o_valid;
        n_o_val    = r_o_val;
        n_o_row    = r_o_row;
        n_o_col    = r_o_col;
        n_o_last   = r_o_last;

        // output register frees on transfer
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            scv_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_op = i_operation;
                    n_s  = '0;
                    n_state = w_win_load ? scv_pkg::ST_XSTART : scv_pkg::ST_CHECK;
                end
            end
            scv_pkg::ST_XSTART: begin
                if (w_col_s < (CW+1)'(w_hh)) begin
                    n_state = scv_pkg::ST_XNEXT;
                end else begin
                    n_j     = r_s;
                    n_acc   = '0;
                    n_state = scv_pkg::ST_XMUL;
                end
            end
            scv_pkg::ST_XMUL: begin
                if (r_j < w_t) begin
                    n_prod  = PROD_W'(w_xprod);
                    n_state = scv_pkg::ST_XACC;
                end else begin
                    n_state = scv_pkg::ST_XWR;
                end
            end
            scv_pkg::ST_XACC: begin
                n_acc   = r_acc + ACC_W'(r_prod);
                n_j     = r_j + TW'(1);
                n_state = scv_pkg::ST_XMUL;
            end
            scv_pkg::ST_XWR: begin
                n_state = scv_pkg::ST_XNEXT;
            end
            scv_pkg::ST_XNEXT: begin
                if (r_s < w_s_last) begin
                    n_s     = r_s + TW'(1);
                    n_state = scv_pkg::ST_XSTART;
                end else begin
                    // advance the input position
                    if (w_in_last_col) begin
                        n_in_col = '0;
                        if (w_in_last_row) begin
                            n_in_row  = '0;
                            n_in_slot = '0;
                            n_done    = 1'b1;
                        end else begin
                            n_in_row  = r_in_row + RW'(1);
                            n_in_slot = (r_in_slot == SW'(MAX_TAPS - 1)) ? '0
                                                                         : r_in_slot + SW'(1);
                        end
                    end else begin
                        n_in_col = r_in_col + CW'(1);
                    end
                    n_state = scv_pkg::ST_CHECK;
                end
            end
            scv_pkg::ST_CHECK: begin
                if (w_out_ready) begin
                    n_j      = '0;
                    n_acc    = '0;
                    n_sr     = (RW+2)'(r_out_row) + (RW+2)'(w_hh);
                    n_y_slot = SW'(w_slot_sum);
                    n_state  = scv_pkg::ST_YADDR;
                end else begin
                    n_state = scv_pkg::ST_IDLE;
                end
            end
            scv_pkg::ST_YADDR: begin
                if (r_j >= w_t) begin
                    n_state = scv_pkg::ST_EMIT;
                end else if (w_sr_ok) begin
                    n_state = scv_pkg::ST_YMUL;
                end else begin
                    // tap falls outside the frame
                    n_j      = r_j + TW'(1);
                    n_sr     = r_sr - (RW+2)'(1);
                    n_y_slot = (r_y_slot == '0) ? SW'(MAX_TAPS - 1) : r_y_slot - SW'(1);
                end
            end
            scv_pkg::ST_YMUL: begin
                n_prod  = w_yprod;
                n_state = scv_pkg::ST_YACC;
            end
            scv_pkg::ST_YACC: begin
                n_acc    = r_acc + ACC_W'(r_prod);
                n_j      = r_j + TW'(1);
                n_sr     = r_sr - (RW+2)'(1);
                n_y_slot = (r_y_slot == '0) ? SW'(MAX_TAPS - 1) : r_y_slot - SW'(1);
                n_state  = scv_pkg::ST_YADDR;
            end
            scv_pkg::ST_EMIT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_val   = scv_pkg::round_sat(r_acc);
                    n_o_row   = 12'(r_out_row);
                    n_o_col   = 11'(r_out_col);
                    n_o_last  = w_out_last_col && w_out_last_row;
                    if (w_out_last_col) begin
                        n_out_col = '0;
                        if (w_out_last_row) begin
                            // frame complete
                            n_out_row  = '0;
                            n_out_slot = '0;
                            n_in_row   = '0;
                            n_in_col   = '0;
                            n_in_slot  = '0;
                            n_done     = 1'b0;
                        end else begin
                            n_out_row  = r_out_row + RW'(1);
                            n_out_slot = (r_out_slot == SW'(MAX_TAPS - 1)) ? '0
                                                                           : r_out_slot + SW'(1);
                        end
                    end else begin
                        n_out_col = r_out_col + CW'(1);
                    end
                    n_state = scv_pkg::ST_IDLE;
                end
            end
            default: n_state = scv_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= scv_pkg::ST_IDLE;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_slot <= '0;
            r_done     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_in_slot  <= n_in_slot;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_out_slot <= n_out_slot;
            r_done     <= n_done;
            r_o_valid  <= n_o_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_px     <= w_accept ? i_pixel_value : r_px;
        r_y_slot <= n_y_slot;
        r_s      <= n_s;
        r_j      <= n_j;
        r_sr     <= n_sr;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
        r_o_val  <= n_o_val;
        r_o_row  <= n_o_row;
        r_o_col  <= n_o_col;
        r_o_last <= n_o_last;
    end

    // a pixel item that loads the window is recorded as a pixel and starts the x pass
    a_win_load_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_win_load |=> (r_op == scv_pkg::OP_PIXEL) && (r_state == scv_pkg::ST_XSTART) &&
                       (r_px == $past(i_pixel_value)))
        else $error("window load without a pixel item");

    // a finished result waits while the output register is still occupied
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scv_pkg::ST_EMIT && r_o_valid && !i_ready)
            |=> (r_state == scv_pkg::ST_EMIT) && $stable(r_o_val))
        else $error("result overwrote a pending output");

    // each line-store read is followed by its multiply
    a_read_then_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_re |=> (r_state == scv_pkg::ST_YMUL))
        else $error("line store read lost");

    // the last output of a frame rewinds every position
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scv_pkg::ST_EMIT && (!r_o_valid || i_ready) &&
         w_out_last_col && w_out_last_row)
            |=> (r_out_row == '0) && (r_out_col == '0) && (r_in_row == '0) &&
                (r_in_col == '0) && !r_done)
        else $error("frame end did not reset positions");

endmodule

`default_nettype wire
